>>> rtl/core/ssps_pkg.sv
// ----------------------------------------------------------------------------
// ssps_pkg
// Types and constants for the spectrum second-peak shift unit.
// ----------------------------------------------------------------------------
package ssps_pkg;

    localparam int NUM_BINS = 4096;
    localparam int BIN_AW   = $clog2(NUM_BINS);   // bin address width
    localparam int CNT_W    = BIN_AW + 1;         // holds NUM_BINS itself
    localparam int IDX_W    = 12;                 // index fields of a result
    localparam int SHIFT_W  = 13;
    localparam int COUNT_W  = 32;
    localparam int PROD_W   = 48;                 // 16 x 32 product

    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_REF_BIN        = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RATIO_LIMIT    = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_PEAK_COUNT = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RISE_FACTOR    = 8'd3;

    // register reset values
    localparam logic [11:0] RST_REF_BIN        = 12'd499;
    localparam logic [15:0] RST_RATIO_LIMIT    = 16'd5000;
    localparam logic [15:0] RST_MIN_PEAK_COUNT = 16'd6;
    localparam logic [7:0]  RST_RISE_FACTOR    = 8'd10;

    typedef struct packed {
        logic [COUNT_W-1:0] bin_count;
        logic               last_bin;
    } t_in_item;

    typedef struct packed {
        logic signed [SHIFT_W-1:0] shift_bins;
        logic                      second_peak_found;
        logic [IDX_W-1:0]          first_peak_bin;
        logic [IDX_W-1:0]          valley_bin;
        logic [IDX_W-1:0]          second_peak_bin;
        logic [IDX_W-1:0]          used_peak_bin;
    } t_out_item;

endpackage

>>> rtl/core/spectrum_second_peak_shift_unit.sv
// Sequence: after the last bin transfer the unit scans for the first peak, walks to
//   the valley, scans from the valley for the second peak, multiplies for the ratio
//   test and decides; the decision waits while an earlier result is still held.
// Throughput: one bin per cycle to load, one read per cycle per scan, and a check,
//   multiply and compare step per walked bin; input stalls until the result is loaded.
// Reset: synchronous, active low; sequencer and settings reset, memory and datapath kept.
// ----------------------------------------------------------------------------
// spectrum_second_peak_shift_unit
// Stores one spectrum, finds first peak, valley and second peak with one
// sequencer, one memory read port and one shared multiplier, and reports
// the bin shift of the chosen peak.
// ----------------------------------------------------------------------------
module spectrum_second_peak_shift_unit
    import ssps_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // input bins
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_in_item              i_in_data,
    // results
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out_item             o_out_data,
    // register writes
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    typedef enum logic [2:0] {
        S_LOAD,   // taking bins
        S_MAX,    // pipelined first-maximum scan (both peaks)
        S_VCHK,   // valley walk: end test, memory read in flight
        S_VMUL,   // valley walk: rise_factor * minimum
        S_VCMP,   // valley walk: compare and track minimum
        S_RMUL,   // ratio_limit * second peak height
        S_DEC     // decision, load result register
    } t_state;

    // ---- storage ----
    logic [COUNT_W-1:0] r_mem [NUM_BINS];
    logic [COUNT_W-1:0] r_rd_data;

    // ---- registers ----
    t_state              r_state;
    logic [CNT_W-1:0]    r_load_cnt;
    logic [CNT_W-1:0]    r_n;          // bins in the spectrum under analysis
    logic [CNT_W-1:0]    r_idx;        // scan / walk position
    logic                r_rd_vld;     // read data in r_rd_data belongs to a scan
    logic [BIN_AW-1:0]   r_rd_idx;
    logic                r_first;      // next scan read is the start bin
    logic                r_pass;       // 0: first peak scan, 1: second peak scan
    logic [BIN_AW-1:0]   r_best_idx;
    logic [COUNT_W-1:0]  r_best_cnt;
    logic [BIN_AW-1:0]   r_low_idx;
    logic [COUNT_W-1:0]  r_low_cnt;
    logic [BIN_AW-1:0]   r_p1;
    logic [COUNT_W-1:0]  r_h1;
    logic [BIN_AW-1:0]   r_p2;
    logic [PROD_W-1:0]   r_prod;
    logic                r_out_vld;
    t_out_item           r_out;

    logic [11:0]         r_ref_bin;
    logic [15:0]         r_ratio_limit;
    logic [15:0]         r_min_peak;
    logic [7:0]          r_rise_factor;

    // ---- combinational ----
    logic                w_in_acc;
    logic                w_wr_en;
    logic [BIN_AW-1:0]   w_rd_addr;
    logic [15:0]         w_mul_a;
    logic [COUNT_W-1:0]  w_mul_b;
    logic [PROD_W-1:0]   w_mul_p;
    logic [CNT_W:0]      w_next_pos;   // walk position + 1, one extra bit
    logic                w_walk_end;
    logic                w_found;
    logic [IDX_W-1:0]    w_used;

    assign o_in_stall  = (r_state != S_LOAD);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

    assign w_in_acc  = i_in_valid && !o_in_stall;
    // bins past the memory depth are dropped
    assign w_wr_en   = w_in_acc && (r_load_cnt < CNT_W'(NUM_BINS));
    assign w_rd_addr = r_idx[BIN_AW-1:0];

    // shared multiplier: rise test during the walk, ratio test at the end
    assign w_mul_a = (r_state == S_VMUL) ? {8'd0, r_rise_factor} : r_ratio_limit;
    assign w_mul_b = (r_state == S_VMUL) ? r_low_cnt : r_best_cnt;
    assign w_mul_p = PROD_W'(w_mul_a) * PROD_W'(w_mul_b);

    // walk never examines the last bin; a zero minimum ends it at once
    assign w_next_pos = {1'b0, r_idx} + (CNT_W+1)'(1);
    assign w_walk_end = (w_next_pos >= {1'b0, r_n}) || (r_low_cnt == '0);

    // second peak height sits in r_best_cnt after the second scan
    assign w_found = ({16'd0, r_h1} < r_prod) &&
                     (r_best_cnt > {16'd0, r_min_peak});
    assign w_used  = w_found ? IDX_W'(r_p2) : IDX_W'(r_p1);

    // ---- bin memory: one write port, one registered read port ----
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[r_load_cnt[BIN_AW-1:0]] <= i_in_data.bin_count;
        end
        r_rd_data <= r_mem[w_rd_addr];
    end

    // ---- registers ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ref_bin     <= RST_REF_BIN;
            r_ratio_limit <= RST_RATIO_LIMIT;
            r_min_peak    <= RST_MIN_PEAK_COUNT;
            r_rise_factor <= RST_RISE_FACTOR;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_REF_BIN:        r_ref_bin     <= i_cfg_data[11:0];
                CFG_RATIO_LIMIT:    r_ratio_limit <= i_cfg_data;
                CFG_MIN_PEAK_COUNT: r_min_peak    <= i_cfg_data;
                CFG_RISE_FACTOR:    r_rise_factor <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // ---- sequencer ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_LOAD;
            r_load_cnt <= '0;
            r_rd_vld   <= 1'b0;
            r_out_vld  <= 1'b0;
            r_first    <= 1'b0;
            r_pass     <= 1'b0;
            r_idx      <= '0;
            r_n        <= '0;
        end else begin
            if (r_out_vld && !i_out_stall) begin
                r_out_vld <= 1'b0;
            end

            case (r_state)
                S_LOAD: begin
                    if (w_in_acc) begin
                        if (i_in_data.last_bin) begin
                            r_n        <= w_wr_en ? r_load_cnt + CNT_W'(1) : r_load_cnt;
                            r_load_cnt <= '0;
                            r_idx      <= '0;
                            r_first    <= 1'b1;
                            r_pass     <= 1'b0;
                            r_rd_vld   <= 1'b0;
                            r_state    <= S_MAX;
                        end else if (w_wr_en) begin
                            r_load_cnt <= r_load_cnt + CNT_W'(1);
                        end
                    end
                end

                S_MAX: begin
                    // issue one read a cycle, evaluate the one returned
                    if (r_idx < r_n) begin
                        r_idx    <= r_idx + CNT_W'(1);
                        r_rd_vld <= 1'b1;
                        r_rd_idx <= r_idx[BIN_AW-1:0];
                    end else begin
                        r_rd_vld <= 1'b0;
                    end

                    if (r_rd_vld) begin
                        if (r_first || (r_rd_data > r_best_cnt)) begin
                            r_best_cnt <= r_rd_data;
                            r_best_idx <= r_rd_idx;
                        end
                        r_first <= 1'b0;
                    end

                    if (!r_rd_vld && (r_idx >= r_n)) begin
                        if (!r_pass) begin
                            r_p1      <= r_best_idx;
                            r_h1      <= r_best_cnt;
                            r_low_idx <= r_best_idx;
                            r_low_cnt <= r_best_cnt;
                            r_idx     <= {1'b0, r_best_idx} + CNT_W'(1);
                            r_state   <= S_VCHK;
                        end else begin
                            r_p2    <= r_best_idx;
                            r_state <= S_RMUL;
                        end
                    end
                end

                S_VCHK: begin
                    if (w_walk_end) begin
                        r_idx   <= {1'b0, r_low_idx};
                        r_first <= 1'b1;
                        r_pass  <= 1'b1;
                        r_state <= S_MAX;
                    end else begin
                        r_state <= S_VMUL;
                    end
                end

                S_VMUL: begin
                    r_prod  <= w_mul_p;
                    r_state <= S_VCMP;
                end

                S_VCMP: begin
                    if ({16'd0, r_rd_data} >= r_prod) begin
                        // count rose far enough: valley is settled
                        r_idx   <= {1'b0, r_low_idx};
                        r_first <= 1'b1;
                        r_pass  <= 1'b1;
                        r_state <= S_MAX;
                    end else begin
                        if (r_rd_data < r_low_cnt) begin
                            r_low_cnt <= r_rd_data;
                            r_low_idx <= r_idx[BIN_AW-1:0];
                        end
                        r_idx   <= r_idx + CNT_W'(1);
                        r_state <= S_VCHK;
                    end
                end

                S_RMUL: begin
                    r_prod  <= w_mul_p;
                    r_state <= S_DEC;
                end

                S_DEC: begin
                    // hold until the previous result has been taken
                    if (!r_out_vld) begin
                        r_out.shift_bins        <= $signed({1'b0, r_ref_bin} - {1'b0, w_used});
                        r_out.second_peak_found <= w_found;
                        r_out.first_peak_bin    <= IDX_W'(r_p1);
                        r_out.valley_bin        <= IDX_W'(r_low_idx);
                        r_out.second_peak_bin   <= IDX_W'(r_p2);
                        r_out.used_peak_bin     <= w_used;
                        r_out_vld               <= 1'b1;
                        r_state                 <= S_LOAD;
                    end
                end

                default: begin
                    r_state <= S_LOAD;
                end
            endcase
        end
    end

    // ---- assertions ----
    a_last_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && i_in_data.last_bin) |=> o_in_stall)
        else $error("input not stalled after last bin transfer");

    a_load_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_load_cnt <= CNT_W'(NUM_BINS))
        else $error("load count past memory depth");

    a_out_from_dec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == S_DEC))
        else $error("result raised outside decision step");

    a_used_peak: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.used_peak_bin ==
            (o_out_data.second_peak_found ? o_out_data.second_peak_bin
                                          : o_out_data.first_peak_bin)))
        else $error("used peak does not match decision");

    a_walk_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_VCMP) |-> (w_next_pos < {1'b0, r_n}))
        else $error("valley walk examined the last bin");

endmodule
